// ===== hw/rtl/scln_pkg.sv =====
// shared types and constants of the source character line normalizer
package scln_pkg;

    // byte codes the classifier looks for
    localparam logic [7:0] BYTE_LF  = 8'h0A;
    localparam logic [7:0] BYTE_CR  = 8'h0D;
    localparam logic [7:0] BYTE_BS  = 8'h5C;
    localparam logic [7:0] SIG_B0   = 8'hEF;
    localparam logic [7:0] SIG_B1   = 8'hBB;
    localparam logic [7:0] SIG_B2   = 8'hBF;

    // codes carried by newline results
    localparam logic [7:0] CODE_NEWLINE     = 8'h0A;
    localparam logic [7:0] CODE_ESC_NEWLINE = 8'h0D;
    localparam logic [7:0] CODE_END         = 8'h00;

    // at most this many results per input beat
    localparam int MAX_OPS = 3;

    typedef enum logic [1:0] {
        PEND_NONE  = 2'd0,
        PEND_CR    = 2'd1,
        PEND_BS    = 2'd2,
        PEND_BS_CR = 2'd3
    } pend_t;

    typedef enum logic [1:0] {
        SIG_START = 2'd0,
        SIG_EF    = 2'd1,
        SIG_EFBB  = 2'd2,
        SIG_DONE  = 2'd3
    } sig_t;

    typedef enum logic [1:0] {
        OP_CHAR = 2'd0,
        OP_LINE = 2'd1,
        OP_END  = 2'd2
    } op_kind_t;

    // one result to produce: plain char, newline of 1..3 bytes, or end marker
    typedef struct packed {
        op_kind_t    kind;
        logic [7:0]  code;
        logic [1:0]  nbytes;
    } op_t;

    // everything one input beat turns into
    typedef struct packed {
        logic [1:0]             count;
        op_t [MAX_OPS-1:0]      ops;
    } desc_t;

endpackage

// ===== hw/rtl/scln_front.sv =====
// front end: takes input beats, tracks pending bytes and signature, builds descriptors
module scln_front
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_wr_en,
    input  logic               cfg_wr_data,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [7:0]         byte_value,
    input  logic               end_of_file,
    input  logic               q_full,
    output logic               q_push,
    output scln_pkg::desc_t    q_data
);

    logic               strip_reg;
    scln_pkg::pend_t    pend_reg;
    scln_pkg::pend_t    pend_next;
    scln_pkg::sig_t     sig_reg;
    scln_pkg::sig_t     sig_next;
    scln_pkg::desc_t    desc;
    logic               accept;

    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;
    assign q_push   = accept && (desc.count != 2'd0);
    assign q_data   = desc;

    // configuration and classifier state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            strip_reg <= 1'b1;
            pend_reg  <= scln_pkg::PEND_NONE;
            sig_reg   <= scln_pkg::SIG_START;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                strip_reg <= cfg_wr_data;
            end
            if (accept)
            begin
                pend_reg <= pend_next;
                sig_reg  <= sig_next;
            end
        end
    end

    // classify one beat into a list of result ops
    always_comb
    begin
        logic [1:0] n;
        logic       do_normal;
        logic       fresh;
        scln_pkg::op_t op_char_ef;
        scln_pkg::op_t op_char_bb;
        scln_pkg::op_t op_char_bs;
        scln_pkg::op_t op_char_b;
        n          = 2'd0;
        do_normal  = 1'b0;
        fresh      = 1'b0;
        op_char_ef = '{kind: scln_pkg::OP_CHAR, code: scln_pkg::SIG_B0, nbytes: 2'd1};
        op_char_bb = '{kind: scln_pkg::OP_CHAR, code: scln_pkg::SIG_B1, nbytes: 2'd1};
        op_char_bs = '{kind: scln_pkg::OP_CHAR, code: scln_pkg::BYTE_BS, nbytes: 2'd1};
        op_char_b  = '{kind: scln_pkg::OP_CHAR, code: byte_value, nbytes: 2'd1};
        desc       = '0;
        pend_next  = pend_reg;
        sig_next   = sig_reg;

        if (end_of_file)
        begin
            // flush partial signature and pending bytes, then the end marker
            if (sig_reg == scln_pkg::SIG_EF || sig_reg == scln_pkg::SIG_EFBB)
            begin
                desc.ops[n] = op_char_ef;
                n = n + 2'd1;
            end
            if (sig_reg == scln_pkg::SIG_EFBB)
            begin
                desc.ops[n] = op_char_bb;
                n = n + 2'd1;
            end
            case (pend_reg)
                scln_pkg::PEND_CR:
                begin
                    desc.ops[n] = '{kind: scln_pkg::OP_LINE,
                                    code: scln_pkg::CODE_NEWLINE, nbytes: 2'd1};
                    n = n + 2'd1;
                end
                scln_pkg::PEND_BS:
                begin
                    desc.ops[n] = op_char_bs;
                    n = n + 2'd1;
                end
                scln_pkg::PEND_BS_CR:
                begin
                    desc.ops[n] = '{kind: scln_pkg::OP_LINE,
                                    code: scln_pkg::CODE_ESC_NEWLINE, nbytes: 2'd2};
                    n = n + 2'd1;
                end
                default:
                begin
                end
            endcase
            desc.ops[n] = '{kind: scln_pkg::OP_END, code: scln_pkg::CODE_END, nbytes: 2'd0};
            n = n + 2'd1;
            pend_next = scln_pkg::PEND_NONE;
            sig_next  = scln_pkg::SIG_START;
        end
        else
        begin
            // signature check at file start
            case (sig_reg)
                scln_pkg::SIG_START:
                begin
                    if (strip_reg && byte_value == scln_pkg::SIG_B0)
                    begin
                        sig_next = scln_pkg::SIG_EF;
                    end
                    else
                    begin
                        sig_next  = scln_pkg::SIG_DONE;
                        do_normal = 1'b1;
                    end
                end
                scln_pkg::SIG_EF:
                begin
                    if (byte_value == scln_pkg::SIG_B1)
                    begin
                        sig_next = scln_pkg::SIG_EFBB;
                    end
                    else
                    begin
                        sig_next    = scln_pkg::SIG_DONE;
                        desc.ops[n] = op_char_ef;
                        n = n + 2'd1;
                        do_normal   = 1'b1;
                    end
                end
                scln_pkg::SIG_EFBB:
                begin
                    sig_next = scln_pkg::SIG_DONE;
                    if (byte_value != scln_pkg::SIG_B2)
                    begin
                        desc.ops[n] = op_char_ef;
                        n = n + 2'd1;
                        desc.ops[n] = op_char_bb;
                        n = n + 2'd1;
                        do_normal   = 1'b1;
                    end
                end
                default:
                begin
                    do_normal = 1'b1;
                end
            endcase

            // resolve the pending byte against this one
            if (do_normal)
            begin
                pend_next = scln_pkg::PEND_NONE;
                fresh     = 1'b1;
                case (pend_reg)
                    scln_pkg::PEND_CR:
                    begin
                        if (byte_value == scln_pkg::BYTE_LF)
                        begin
                            desc.ops[n] = '{kind: scln_pkg::OP_LINE,
                                            code: scln_pkg::CODE_NEWLINE, nbytes: 2'd2};
                            fresh = 1'b0;
                        end
                        else
                        begin
                            desc.ops[n] = '{kind: scln_pkg::OP_LINE,
                                            code: scln_pkg::CODE_NEWLINE, nbytes: 2'd1};
                        end
                        n = n + 2'd1;
                    end
                    scln_pkg::PEND_BS:
                    begin
                        if (byte_value == scln_pkg::BYTE_LF)
                        begin
                            desc.ops[n] = '{kind: scln_pkg::OP_LINE,
                                            code: scln_pkg::CODE_ESC_NEWLINE, nbytes: 2'd2};
                            n = n + 2'd1;
                            fresh = 1'b0;
                        end
                        else if (byte_value == scln_pkg::BYTE_CR)
                        begin
                            pend_next = scln_pkg::PEND_BS_CR;
                            fresh     = 1'b0;
                        end
                        else
                        begin
                            desc.ops[n] = op_char_bs;
                            n = n + 2'd1;
                        end
                    end
                    scln_pkg::PEND_BS_CR:
                    begin
                        if (byte_value == scln_pkg::BYTE_LF)
                        begin
                            desc.ops[n] = '{kind: scln_pkg::OP_LINE,
                                            code: scln_pkg::CODE_ESC_NEWLINE, nbytes: 2'd3};
                            fresh = 1'b0;
                        end
                        else
                        begin
                            desc.ops[n] = '{kind: scln_pkg::OP_LINE,
                                            code: scln_pkg::CODE_ESC_NEWLINE, nbytes: 2'd2};
                        end
                        n = n + 2'd1;
                    end
                    default:
                    begin
                    end
                endcase

                // the byte itself with nothing pending
                if (fresh)
                begin
                    if (byte_value == scln_pkg::BYTE_CR)
                    begin
                        pend_next = scln_pkg::PEND_CR;
                    end
                    else if (byte_value == scln_pkg::BYTE_BS)
                    begin
                        pend_next = scln_pkg::PEND_BS;
                    end
                    else if (byte_value == scln_pkg::BYTE_LF)
                    begin
                        desc.ops[n] = '{kind: scln_pkg::OP_LINE,
                                        code: scln_pkg::CODE_NEWLINE, nbytes: 2'd1};
                        n = n + 2'd1;
                    end
                    else
                    begin
                        desc.ops[n] = op_char_b;
                        n = n + 2'd1;
                    end
                end
            end
        end
        desc.count = n;
    end

endmodule

// ===== hw/rtl/scln_queue.sv =====
// short descriptor queue between front end and back end
module scln_queue
#(
    parameter int DEPTH = 4
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  scln_pkg::desc_t    push_data,
    output logic               full,
    input  logic               pop,
    output logic               not_empty,
    output scln_pkg::desc_t    head
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    scln_pkg::desc_t    entry_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;

    assign full      = (count_reg == FULL_CNT);
    assign not_empty = (count_reg != '0);
    assign head      = entry_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    // pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + PTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + PTR_W'(1);
            end
            count_reg <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ===== hw/rtl/scln_back.sv =====
// back end: walks descriptors one op a cycle if unstalled, counts, drives results
module scln_back
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               q_not_empty,
    input  scln_pkg::desc_t    q_head,
    output logic               q_pop,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [7:0]         char_code,
    output logic [31:0]        line_number,
    output logic [31:0]        column,
    output logic [31:0]        byte_count,
    output logic [31:0]        codepoint_count,
    output logic               is_end,
    output logic               last_of_run
);

    logic [1:0]     idx_reg;
    logic           out_valid_reg;
    logic [31:0]    line_reg;
    logic [31:0]    col_reg;
    logic [31:0]    bytes_reg;
    logic [31:0]    cps_reg;
    logic [31:0]    line_next;
    logic [31:0]    col_next;
    logic [31:0]    bytes_next;
    logic [31:0]    cps_next;
    logic [7:0]     code_reg;
    logic           is_end_reg;
    logic           last_reg;
    scln_pkg::op_t  cur_op;
    logic           load;
    logic           is_last;

    assign cur_op  = q_head.ops[idx_reg];
    assign load    = q_not_empty && (!out_valid_reg || out_ready);
    assign is_last = (idx_reg == q_head.count - 2'd1);
    assign q_pop   = load && is_last;

    // counter update for the current op
    always_comb
    begin
        line_next  = line_reg;
        col_next   = col_reg;
        bytes_next = bytes_reg;
        cps_next   = cps_reg;
        case (cur_op.kind)
            scln_pkg::OP_CHAR:
            begin
                bytes_next = bytes_reg + 32'd1;
                col_next   = col_reg + 32'd1;
                if (cur_op.code[7:6] != 2'b10)
                begin
                    cps_next = cps_reg + 32'd1;
                end
            end
            scln_pkg::OP_LINE:
            begin
                bytes_next = bytes_reg + {30'd0, cur_op.nbytes};
                cps_next   = cps_reg + {30'd0, cur_op.nbytes};
                line_next  = line_reg + 32'd1;
                col_next   = '0;
            end
            default:
            begin
            end
        endcase
    end

    // control and counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
            line_reg      <= 32'd1;
            col_reg       <= '0;
            bytes_reg     <= '0;
            cps_reg       <= '0;
        end
        else
        begin
            if (load)
            begin
                idx_reg       <= is_last ? 2'd0 : idx_reg + 2'd1;
                out_valid_reg <= 1'b1;
                line_reg      <= line_next;
                col_reg       <= col_next;
                bytes_reg     <= bytes_next;
                cps_reg       <= cps_next;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // output payload
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            code_reg   <= cur_op.code;
            is_end_reg <= (cur_op.kind == scln_pkg::OP_END);
            last_reg   <= is_last;
        end
    end

    assign out_valid       = out_valid_reg;
    assign char_code       = code_reg;
    assign line_number     = line_reg;
    assign column          = col_reg;
    assign byte_count      = bytes_reg;
    assign codepoint_count = cps_reg;
    assign is_end          = is_end_reg;
    assign last_of_run     = last_reg;

endmodule

// ===== hw/rtl/source_char_line_normalizer.sv =====
// top level of the source character line normalizer
// Source bytes enter on the input channel (in_valid/in_ready, byte_value,
// end_of_file), one beat per byte. Normalized characters leave on the
// output channel (out_valid/out_ready) with line, column, byte and
// code point counts as they stand after each character.
// The front end classifies each beat in the cycle it is accepted and
// writes a descriptor of up to three results into a short queue; the back
// end moves one result a cycle from it to the output register when not
// stalled, and this walk sets the rate. A beat's first result passes a
// queue entry, then the output register. One beat per cycle is taken
// while each beat yields one result and the receiver is ready; a beat
// yielding two or three results holds the back end until all have left;
// beats that yield none (CR, backslash, signature bytes) add no work.
// A stalled receiver holds the output register; the queue keeps taking
// beats until it is full, then in_ready drops.
// Reset empties the queue and output, sets line to 1, all other counts to
// 0, and arms the signature check with strip_signature set to 1.
// cfg_wr_en writes strip_signature from cfg_wr_data.
module source_char_line_normalizer
#(
    parameter int QUEUE_DEPTH = 4
)
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           cfg_wr_en,
    input  logic           cfg_wr_data,
    input  logic           in_valid,
    output logic           in_ready,
    input  logic [7:0]     byte_value,
    input  logic           end_of_file,
    output logic           out_valid,
    input  logic           out_ready,
    output logic [7:0]     char_code,
    output logic [31:0]    line_number,
    output logic [31:0]    column,
    output logic [31:0]    byte_count,
    output logic [31:0]    codepoint_count,
    output logic           is_end,
    output logic           last_of_run
);

    logic               q_full;
    logic               q_push;
    logic               q_pop;
    logic               q_not_empty;
    scln_pkg::desc_t    q_wdata;
    scln_pkg::desc_t    q_head;

    // classify input beats
    scln_front u_front
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .byte_value  (byte_value),
        .end_of_file (end_of_file),
        .q_full      (q_full),
        .q_push      (q_push),
        .q_data      (q_wdata)
    );

    // decouple front and back
    scln_queue #(.DEPTH(QUEUE_DEPTH)) u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_wdata),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .head      (q_head)
    );

    // produce results
    scln_back u_back
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .q_not_empty     (q_not_empty),
        .q_head          (q_head),
        .q_pop           (q_pop),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .char_code       (char_code),
        .line_number     (line_number),
        .column          (column),
        .byte_count      (byte_count),
        .codepoint_count (codepoint_count),
        .is_end          (is_end),
        .last_of_run     (last_of_run)
    );

endmodule
